### sv/rprp_pkg.sv
// Shared types and constants for the resident page replacement policy unit.
// No dependencies; imported by the interfaces, the memory and the top level.
package rprp_pkg;

   localparam int OP_W     = 2;
   localparam int PAGE_W   = 20;
   localparam int MODE_W   = 2;
   localparam int RCOUNT_W = 5;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH   = 2'd0,
      OP_REMOVE = 2'd1,
      OP_TOUCH  = 2'd2,
      OP_TICK   = 2'd3
   } op_type;

   localparam logic [MODE_W-1:0] MODE_LIFO   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SECOND = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LEAST  = 2'd2;

   // field write masks: bit 0 field a, bit 1 field b
   localparam logic [1:0] WM_NONE = 2'b00;
   localparam logic [1:0] WM_A    = 2'b01;
   localparam logic [1:0] WM_B    = 2'b10;
   localparam logic [1:0] WM_BOTH = 2'b11;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_FIND,
      ST_TICK,
      ST_UL_RD,
      ST_UL_LO,
      ST_UL_HI,
      ST_FULL,
      ST_EV_RD,
      ST_EV_DAT,
      ST_LA_RD,
      ST_LA_DAT,
      ST_SC_RD,
      ST_SC_DAT,
      ST_SC_MOVE,
      ST_SC_LINK,
      ST_AP_NEW,
      ST_AP_LINK,
      ST_DONE
   } state_type;

endpackage

### sv/rprp_req_if.sv
// Request channel: opcode and page number with valid/ready.
// Depends on rprp_pkg.
interface rprp_req_if import rprp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   opcode;
   logic [PAGE_W-1:0] page_number;

   modport source (output valid, output opcode, output page_number, input ready);
   modport sink   (input valid, input opcode, input page_number, output ready);
endinterface

### sv/rprp_rsp_if.sv
// Response channel: eviction, hit and resident count with valid/ready.
// Depends on rprp_pkg.
interface rprp_rsp_if import rprp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                evicted;
   logic [PAGE_W-1:0]   victim_page;
   logic                found;
   logic [RCOUNT_W-1:0] resident_count;

   modport source (output valid, output evicted, output victim_page, output found,
                   output resident_count, input ready);
   modport sink   (input valid, input evicted, input victim_page, input found,
                   input resident_count, output ready);
endinterface

### sv/rprp_mem.sv
// Two-field synchronous memory, one masked write port and one read port,
// read data registered. Depends on rprp_pkg for the write mask codes.
module rprp_mem import rprp_pkg::*; #(
   parameter int DEPTH = 16,
   parameter int A_W   = 20,
   parameter int B_W   = 16,
   parameter int AW    = 4
) (
   input  logic           clock,
   input  logic [1:0]     wr_mask,
   input  logic [AW-1:0]  wr_addr,
   input  logic [A_W-1:0] wr_a,
   input  logic [B_W-1:0] wr_b,
   input  logic [AW-1:0]  rd_addr,
   output logic [A_W-1:0] rd_a,
   output logic [B_W-1:0] rd_b
);

   logic [A_W-1:0] mem_a [DEPTH];
   logic [B_W-1:0] mem_b [DEPTH];

   always_ff @(posedge clock) begin
      if ((wr_mask & WM_A) != WM_NONE) begin
         mem_a[wr_addr] <= wr_a;
      end
      if ((wr_mask & WM_B) != WM_NONE) begin
         mem_b[wr_addr] <= wr_b;
      end
      rd_a <= mem_a[rd_addr];
      rd_b <= mem_b[rd_addr];
   end

endmodule

### sv/resident_page_replacement_policy_unit.sv
// Resident page replacement policy unit: tracks resident pages in an ordered
// slot list and picks victims by LIFO, second-chance FIFO or least access count.
// Depends on rprp_pkg, rprp_req_if, rprp_rsp_if and rprp_mem.
//
// Usage: req_if carries opcode (push, remove, touch, tick) and page_number;
// a transfer happens when valid and ready are both high. rsp_if returns one
// item per request: evicted, victim_page, found and resident_count.
// csr_wr_en writes policy_mode from csr_wr_data (reset value second-chance).
// Items are handled one at a time. Lookup scans slots until a hit and tick
// scans all slots, one slot a cycle through the slot memory; ST_DONE then
// loads the response. Unlink runs UL_RD, UL_LO, UL_HI; append AP_NEW,
// AP_LINK; eviction EV_RD, EV_DAT plus an unlink and the victim walk: LA_RD,
// LA_DAT per list entry for least access count, SC_RD, SC_DAT, SC_MOVE,
// SC_LINK per step (up to 2 * RESIDENT_SLOTS steps) for second chance. Page
// and count live in one memory, next/prev links in another.
// Reset clears the list, valid and referenced bits at once; no clearing pass.
// A new request is taken while a finished response waits; when the receiver
// stalls, the next response holds in its final state until rsp_if.ready.
module resident_page_replacement_policy_unit import rprp_pkg::*; #(
   parameter int RESIDENT_SLOTS = 16,
   parameter int COUNT_BITS     = 16
) (
   input logic              clock,
   input logic              reset,
   rprp_req_if.sink         req_if,
   rprp_rsp_if.source       rsp_if,
   input logic              csr_wr_en,
   input logic [MODE_W-1:0] csr_wr_data
);

   localparam int IW = (RESIDENT_SLOTS > 1) ? $clog2(RESIDENT_SLOTS) : 1;
   localparam int PW = $clog2(RESIDENT_SLOTS + 1);
   localparam int SW = $clog2(2 * RESIDENT_SLOTS + 1);
   localparam logic [PW-1:0] NIL      = PW'(RESIDENT_SLOTS);
   localparam logic [IW-1:0] LAST     = IW'(RESIDENT_SLOTS - 1);
   localparam logic [SW-1:0] SC_STEPS = SW'(2 * RESIDENT_SLOTS);
   localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

   state_type state_ff, state_in;
   logic [MODE_W-1:0] mode_ff;
   op_type op_ff, op_in;
   logic [PAGE_W-1:0] page_ff, page_in;
   logic [RESIDENT_SLOTS-1:0] valid_ff, valid_in, ref_ff, ref_in;
   logic [PW-1:0] head_ff, head_in, tail_ff, tail_in, total_ff, total_in;
   logic [PW-1:0] idx_ff, idx_in, cur_ff, cur_in, prv_ff, prv_in, best_ff, best_in;
   logic [IW-1:0] pidx_ff, pidx_in, tgt_ff, tgt_in;
   logic pend_ff, pend_in, phase_ff, phase_in;
   logic [SW-1:0] steps_ff, steps_in;
   logic [COUNT_BITS-1:0] bestcnt_ff, bestcnt_in;
   logic evicted_ff, evicted_in, found_ff, found_in;
   logic [PAGE_W-1:0] victim_ff, victim_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_evicted_ff, rsp_evicted_in, rsp_found_ff, rsp_found_in;
   logic [PAGE_W-1:0] rsp_victim_ff, rsp_victim_in;
   logic [RCOUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic [1:0] slot_wm, link_wm;
   logic [IW-1:0] slot_wa, slot_ra, link_wa, link_ra;
   logic [PAGE_W-1:0] slot_wpage, slot_rpage;
   logic [COUNT_BITS-1:0] slot_wcnt, slot_rcnt;
   logic [PW-1:0] link_wnext, link_wprev, link_rnext, link_rprev;
   logic [IW-1:0] free_idx;
   logic free_ok;

   rprp_mem #(.DEPTH(RESIDENT_SLOTS), .A_W(PAGE_W), .B_W(COUNT_BITS), .AW(IW)) u_slot_mem (
      .clock(clock), .wr_mask(slot_wm), .wr_addr(slot_wa), .wr_a(slot_wpage),
      .wr_b(slot_wcnt), .rd_addr(slot_ra), .rd_a(slot_rpage), .rd_b(slot_rcnt)
   );

   rprp_mem #(.DEPTH(RESIDENT_SLOTS), .A_W(PW), .B_W(PW), .AW(IW)) u_link_mem (
      .clock(clock), .wr_mask(link_wm), .wr_addr(link_wa), .wr_a(link_wnext),
      .wr_b(link_wprev), .rd_addr(link_ra), .rd_a(link_rnext), .rd_b(link_rprev)
   );

   always_comb begin
      free_idx = '0;
      free_ok  = 1'b0;
      for (int i = RESIDENT_SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = IW'(i);
            free_ok  = 1'b1;
         end
      end
   end

   assign req_if.ready          = (state_ff == ST_IDLE);
   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.evicted        = rsp_evicted_ff;
   assign rsp_if.victim_page    = rsp_victim_ff;
   assign rsp_if.found          = rsp_found_ff;
   assign rsp_if.resident_count = rsp_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_SECOND;
         valid_ff     <= '0;
         ref_ff       <= '0;
         head_ff      <= NIL;
         tail_ff      <= NIL;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         ref_ff       <= ref_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
      end
      op_ff          <= op_in;
      page_ff        <= page_in;
      idx_ff         <= idx_in;
      cur_ff         <= cur_in;
      prv_ff         <= prv_in;
      best_ff        <= best_in;
      pidx_ff        <= pidx_in;
      tgt_ff         <= tgt_in;
      pend_ff        <= pend_in;
      phase_ff       <= phase_in;
      steps_ff       <= steps_in;
      bestcnt_ff     <= bestcnt_in;
      evicted_ff     <= evicted_in;
      found_ff       <= found_in;
      victim_ff      <= victim_in;
      rsp_evicted_ff <= rsp_evicted_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_victim_ff  <= rsp_victim_in;
      rsp_count_ff   <= rsp_count_in;
   end

   always_comb begin
      state_in = state_ff;  op_in = op_ff;  page_in = page_ff;
      valid_in = valid_ff;  ref_in = ref_ff;
      head_in = head_ff;  tail_in = tail_ff;  total_in = total_ff;
      idx_in = idx_ff;  cur_in = cur_ff;  prv_in = prv_ff;  best_in = best_ff;
      pidx_in = pidx_ff;  tgt_in = tgt_ff;  pend_in = pend_ff;  phase_in = phase_ff;
      steps_in = steps_ff;  bestcnt_in = bestcnt_ff;
      evicted_in = evicted_ff;  found_in = found_ff;  victim_in = victim_ff;
      rsp_valid_in = rsp_valid_ff;  rsp_evicted_in = rsp_evicted_ff;
      rsp_found_in = rsp_found_ff;  rsp_victim_in = rsp_victim_ff;
      rsp_count_in = rsp_count_ff;
      slot_wm = WM_NONE;  slot_wa = '0;  slot_wpage = '0;  slot_wcnt = '0;  slot_ra = '0;
      link_wm = WM_NONE;  link_wa = '0;  link_wnext = '0;  link_wprev = '0;  link_ra = '0;

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               op_in      = op_type'(req_if.opcode);
               page_in    = req_if.page_number;
               idx_in     = '0;
               pend_in    = 1'b0;
               phase_in   = 1'b0;
               evicted_in = 1'b0;
               found_in   = 1'b0;
               victim_in  = '0;
               state_in   = (op_type'(req_if.opcode) == OP_TICK) ? ST_TICK : ST_FIND;
            end
         end
         ST_FIND: begin
            slot_ra = idx_ff[IW-1:0];
            pend_in = (idx_ff < NIL);
            pidx_in = idx_ff[IW-1:0];
            if (idx_ff < NIL) begin
               idx_in = idx_ff + 1'b1;
            end
            if (pend_ff && valid_ff[pidx_ff] && slot_rpage == page_ff) begin
               found_in = 1'b1;
               tgt_in   = pidx_ff;
               if (op_ff == OP_TOUCH) begin
                  ref_in[pidx_ff] = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_UL_RD;
               end
            end else if (pend_ff && pidx_ff == LAST) begin
               state_in = (op_ff == OP_PUSH) ? ST_FULL : ST_DONE;
            end
         end
         ST_TICK: begin
            slot_ra = idx_ff[IW-1:0];
            pend_in = (idx_ff < NIL);
            pidx_in = idx_ff[IW-1:0];
            if (idx_ff < NIL) begin
               idx_in = idx_ff + 1'b1;
            end
            if (pend_ff && valid_ff[pidx_ff] && ref_ff[pidx_ff]) begin
               ref_in[pidx_ff] = 1'b0;
               slot_wm   = WM_B;
               slot_wa   = pidx_ff;
               slot_wcnt = (slot_rcnt != CMAX) ? slot_rcnt + 1'b1 : slot_rcnt;
            end
            if (pend_ff && pidx_ff == LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_UL_RD: begin
            link_ra  = tgt_ff;
            state_in = ST_UL_LO;
         end
         ST_UL_LO: begin
            cur_in = link_rnext;
            prv_in = link_rprev;
            if (link_rprev < NIL) begin
               link_wm    = WM_A;
               link_wa    = link_rprev[IW-1:0];
               link_wnext = link_rnext;
            end
            state_in = ST_UL_HI;
         end
         ST_UL_HI: begin
            if (cur_ff < NIL) begin
               link_wm    = WM_B;
               link_wa    = cur_ff[IW-1:0];
               link_wprev = prv_ff;
            end
            if (head_ff == PW'(tgt_ff)) begin
               head_in = cur_ff;
            end
            if (tail_ff == PW'(tgt_ff)) begin
               tail_in = prv_ff;
            end
            valid_in[tgt_ff] = 1'b0;
            if (total_ff != '0) begin
               total_in = total_ff - 1'b1;
            end
            if (op_ff == OP_REMOVE) begin
               state_in = ST_DONE;
            end else begin
               state_in = phase_ff ? ST_AP_NEW : ST_FULL;
            end
         end
         ST_FULL: begin
            steps_in = '0;
            cur_in   = head_ff;
            if (total_ff >= NIL) begin
               case (mode_ff)
                  MODE_LIFO: begin
                     if (tail_ff < NIL) begin
                        tgt_in   = tail_ff[IW-1:0];
                        state_in = ST_EV_RD;
                     end else begin
                        state_in = ST_AP_NEW;
                     end
                  end
                  MODE_LEAST: begin
                     state_in = (head_ff < NIL) ? ST_LA_RD : ST_AP_NEW;
                  end
                  default: begin
                     state_in = (head_ff < NIL) ? ST_SC_RD : ST_AP_NEW;
                  end
               endcase
            end else begin
               state_in = ST_AP_NEW;
            end
         end
         ST_EV_RD: begin
            slot_ra  = tgt_ff;
            state_in = ST_EV_DAT;
         end
         ST_EV_DAT: begin
            evicted_in = 1'b1;
            victim_in  = slot_rpage;
            phase_in   = 1'b1;
            state_in   = ST_UL_RD;
         end
         ST_LA_RD: begin
            slot_ra  = cur_ff[IW-1:0];
            link_ra  = cur_ff[IW-1:0];
            state_in = ST_LA_DAT;
         end
         ST_LA_DAT: begin
            if (steps_ff == '0 || slot_rcnt < bestcnt_ff) begin
               best_in    = cur_ff;
               bestcnt_in = slot_rcnt;
            end
            steps_in = steps_ff + 1'b1;
            cur_in   = link_rnext;
            if (steps_ff + 1'b1 >= SW'(RESIDENT_SLOTS) || link_rnext >= NIL) begin
               tgt_in   = (steps_ff == '0 || slot_rcnt < bestcnt_ff) ?
                          cur_ff[IW-1:0] : best_ff[IW-1:0];
               state_in = ST_EV_RD;
            end else begin
               state_in = ST_LA_RD;
            end
         end
         ST_SC_RD: begin
            cur_in = head_ff;
            if (!ref_ff[head_ff[IW-1:0]]) begin
               tgt_in   = head_ff[IW-1:0];
               state_in = ST_EV_RD;
            end else begin
               ref_in[head_ff[IW-1:0]] = 1'b0;
               if (tail_ff == head_ff) begin
                  tgt_in   = head_ff[IW-1:0];
                  state_in = ST_EV_RD;
               end else begin
                  link_ra  = head_ff[IW-1:0];
                  state_in = ST_SC_DAT;
               end
            end
         end
         ST_SC_DAT: begin
            head_in    = link_rnext;
            link_wm    = WM_B;
            link_wa    = link_rnext[IW-1:0];
            link_wprev = NIL;
            state_in   = ST_SC_MOVE;
         end
         ST_SC_MOVE: begin
            link_wm    = WM_BOTH;
            link_wa    = cur_ff[IW-1:0];
            link_wnext = NIL;
            link_wprev = tail_ff;
            state_in   = ST_SC_LINK;
         end
         ST_SC_LINK: begin
            link_wm    = WM_A;
            link_wa    = tail_ff[IW-1:0];
            link_wnext = cur_ff;
            tail_in    = cur_ff;
            steps_in   = steps_ff + 1'b1;
            if (steps_ff + 1'b1 == SC_STEPS) begin
               tgt_in   = head_ff[IW-1:0];
               state_in = ST_EV_RD;
            end else begin
               state_in = ST_SC_RD;
            end
         end
         ST_AP_NEW: begin
            if (free_ok) begin
               slot_wm    = WM_BOTH;
               slot_wa    = free_idx;
               slot_wpage = page_ff;
               slot_wcnt  = '0;
               link_wm    = WM_BOTH;
               link_wa    = free_idx;
               link_wnext = NIL;
               link_wprev = tail_ff;
               tgt_in     = free_idx;
               state_in   = ST_AP_LINK;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_AP_LINK: begin
            if (tail_ff < NIL) begin
               link_wm    = WM_A;
               link_wa    = tail_ff[IW-1:0];
               link_wnext = PW'(tgt_ff);
            end
            tail_in = PW'(tgt_ff);
            if (head_ff >= NIL) begin
               head_in = PW'(tgt_ff);
            end
            valid_in[tgt_ff] = 1'b1;
            ref_in[tgt_ff]   = 1'b0;
            total_in         = total_ff + 1'b1;
            state_in         = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_evicted_in = evicted_ff;
               rsp_victim_in  = victim_ff;
               rsp_found_in   = found_ff;
               rsp_count_in   = RCOUNT_W'(total_ff);
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(total_ff))
      else $error("valid bits disagree with resident count");

   a_empty_list: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> ((head_ff == NIL) == (total_ff == '0)) &&
                                ((tail_ff == NIL) == (total_ff == '0)))
      else $error("list ends disagree with resident count");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && !rsp_if.ready)) |->
      $past(state_ff == ST_DONE))
      else $error("response loaded outside final state");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> (state_ff != ST_IDLE))
      else $error("transfer did not start work");

endmodule

### sim/rprp_checker.sv
// Scoreboard for the resident page replacement policy unit: watches both channels
// and the policy register, predicts each response and compares it field by field.
// Depends on rprp_pkg, rprp_req_if and rprp_rsp_if.
module rprp_checker import rprp_pkg::*; #(
   parameter int SLOTS      = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   rprp_req_if               mon_req,
   rprp_rsp_if               mon_rsp,
   input  logic              csr_wr_en,
   input  logic [MODE_W-1:0] csr_wr_data,
   output int                fail_count,
   output int                pending,
   output int                evict_count,
   output int                hit_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic                evicted;
      logic [PAGE_W-1:0]   victim_page;
      logic                found;
      logic [RCOUNT_W-1:0] resident_count;
   } outcome_type;

   localparam int NIL = SLOTS;
   localparam logic [COUNT_BITS-1:0] COUNT_SAT = '1;

   outcome_type           predicted_outcomes[$];
   logic [MODE_W-1:0]     mode;
   logic [PAGE_W-1:0]     pg[SLOTS];
   logic [COUNT_BITS-1:0] cnt[SLOTS];
   bit                    vld[SLOTS];
   bit                    refd[SLOTS];
   int                    nxt[SLOTS];
   int                    prv[SLOTS];
   int                    head, tail, total;

   function automatic void clear_list();
      for (int i = 0; i < SLOTS; i++) begin
         vld[i] = 0; refd[i] = 0; pg[i] = '0; cnt[i] = '0; nxt[i] = 0; prv[i] = 0;
      end
      head = NIL; tail = NIL; total = 0;
   endfunction

   function automatic void detach(int s);
      int p, n;
      p = prv[s];
      n = nxt[s];
      if (p < NIL) nxt[p] = n;
      if (n < NIL) prv[n] = p;
      if (head == s) head = n;
      if (tail == s) tail = p;
      vld[s] = 0;
      if (total > 0) total--;
   endfunction

   function automatic int lookup(logic [PAGE_W-1:0] page);
      int s;
      s = head;
      for (int k = 0; k < SLOTS && s < NIL; k++) begin
         if (vld[s] && pg[s] == page) return s;
         s = nxt[s];
      end
      return NIL;
   endfunction

   function automatic int second_chance_victim();
      int s;
      for (int k = 0; k < 2 * SLOTS; k++) begin
         s = head;
         if (s >= NIL) return NIL;
         if (!refd[s]) return s;
         refd[s] = 0;
         if (tail == s) return s;
         head = nxt[s];
         if (head < NIL) prv[head] = NIL;
         nxt[s] = NIL;
         prv[s] = tail;
         nxt[tail] = s;
         tail = s;
      end
      return head;
   endfunction

   function automatic int least_accessed_victim();
      int s, best;
      s = head;
      best = head;
      for (int k = 0; k < SLOTS && s < NIL; k++) begin
         if (cnt[s] < cnt[best]) best = s;
         s = nxt[s];
      end
      return best;
   endfunction

   function automatic outcome_type apply_page_op(op_type op, logic [PAGE_W-1:0] page);
      outcome_type o;
      int s, v;
      o = '0;
      case (op)
         OP_PUSH: begin
            s = lookup(page);
            if (s < NIL) begin
               o.found = 1;
               detach(s);
            end
            if (total >= SLOTS) begin
               if (mode == MODE_LIFO) v = tail;
               else if (mode == MODE_LEAST) v = least_accessed_victim();
               else v = second_chance_victim();
               if (v < NIL) begin
                  o.evicted = 1;
                  o.victim_page = pg[v];
                  detach(v);
               end
            end
            s = 0;
            while (s < SLOTS && vld[s]) s++;
            if (s < NIL) begin
               vld[s] = 1; pg[s] = page; refd[s] = 0; cnt[s] = '0;
               nxt[s] = NIL;
               prv[s] = tail;
               if (tail < NIL) nxt[tail] = s;
               tail = s;
               if (head >= NIL) head = s;
               total++;
            end
         end
         OP_REMOVE: begin
            s = lookup(page);
            if (s < NIL) begin
               o.found = 1;
               detach(s);
            end
         end
         OP_TOUCH: begin
            s = lookup(page);
            if (s < NIL) begin
               o.found = 1;
               refd[s] = 1;
            end
         end
         default: begin
            s = head;
            for (int k = 0; k < SLOTS && s < NIL; k++) begin
               if (refd[s]) begin
                  refd[s] = 0;
                  if (cnt[s] != COUNT_SAT) cnt[s]++;
               end
               s = nxt[s];
            end
         end
      endcase
      o.resident_count = total[RCOUNT_W-1:0];
      return o;
   endfunction

   assign pending = predicted_outcomes.size();

   always @(posedge clock) begin
      outcome_type e;
      if (reset) begin
         mode = MODE_SECOND;
         clear_list();
         predicted_outcomes.delete();
         fail_count = 0; evict_count = 0; hit_count = 0;
      end else begin
         if (csr_wr_en) mode = csr_wr_data;
         if (mon_req.valid && mon_req.ready)
            predicted_outcomes.push_back(apply_page_op(op_type'(mon_req.opcode),
                                                       mon_req.page_number));
         if (mon_rsp.valid && mon_rsp.ready) begin
            if (predicted_outcomes.size() == 0) begin
               $error("unexpected response transfer");
               fail_count++;
            end else begin
               e = predicted_outcomes.pop_front();
               if (e.evicted) evict_count++;
               if (e.found) hit_count++;
               if (mon_rsp.evicted !== e.evicted) begin
                  $error("evicted: expected %0d, got %0d", e.evicted, mon_rsp.evicted);
                  fail_count++;
               end
               if (mon_rsp.victim_page !== e.victim_page) begin
                  $error("victim_page: expected %h, got %h", e.victim_page,
                         mon_rsp.victim_page);
                  fail_count++;
               end
               if (mon_rsp.found !== e.found) begin
                  $error("found: expected %0d, got %0d", e.found, mon_rsp.found);
                  fail_count++;
               end
               if (mon_rsp.resident_count !== e.resident_count) begin
                  $error("resident_count: expected %0d, got %0d", e.resident_count,
                         mon_rsp.resident_count);
                  fail_count++;
               end
            end
         end
      end
   end
endmodule

### sim/tb_resident_page_replacement_policy_unit.sv
// Top of the testbench: clock, reset, request and policy stimulus, response stalls
// and the verdict. Depends on rprp_pkg, both channel interfaces and rprp_checker.
module tb_resident_page_replacement_policy_unit import rprp_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PHASE_ITEMS = 165;

   logic              clock = 0;
   logic              reset = 1;
   logic              csr_wr_en = 0;
   logic [MODE_W-1:0] csr_wr_data = '0;
   int                fail_count, pending, evict_count, hit_count;
   int                sent = 0;
   logic [PAGE_W-1:0] page_pool[24];

   rprp_req_if req_ch();
   rprp_rsp_if rsp_ch();

   resident_page_replacement_policy_unit dut (
      .clock(clock), .reset(reset), .req_if(req_ch), .rsp_if(rsp_ch),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   rprp_checker chk (
      .clock(clock), .reset(reset), .mon_req(req_ch), .mon_rsp(rsp_ch),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data), .fail_count(fail_count),
      .pending(pending), .evict_count(evict_count), .hit_count(hit_count)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   initial begin
      req_ch.valid = 0;
      req_ch.opcode = OP_PUSH;
      req_ch.page_number = '0;
      rsp_ch.ready = 0;
   end

   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // receiver: one long hold-off, one quiet window, random stalls otherwise
   initial begin
      int cyc;
      cyc = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         cyc++;
         if (cyc >= 3000 && cyc < 3400) rsp_ch.ready <= 0;
         else if (cyc >= 6000 && cyc < 9000) rsp_ch.ready <= 1;
         else rsp_ch.ready <= ($urandom_range(99) >= 14);
      end
   end

   task automatic send(op_type op, logic [PAGE_W-1:0] page);
      bit quiet;
      quiet = (sent >= 400 && sent < 520);
      while (!quiet && $urandom_range(99) < 14) begin
         req_ch.valid <= 0;
         @(posedge clock);
      end
      req_ch.valid <= 1;
      req_ch.opcode <= op;
      req_ch.page_number <= page;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent++;
   endtask

   task automatic set_policy(logic [MODE_W-1:0] m);
      req_ch.valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_wr_en <= 1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en <= 0;
      @(posedge clock);
   endtask

   task automatic random_phase(int touch_bias);
      int r;
      op_type op;
      logic [PAGE_W-1:0] page;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         r = $urandom_range(99);
         if (r < 45 - touch_bias) op = OP_PUSH;
         else if (r < 58 - touch_bias) op = OP_REMOVE;
         else if (r < 85) op = OP_TOUCH;
         else op = OP_TICK;
         page = ($urandom_range(9) == 0) ? PAGE_W'($urandom) :
                page_pool[$urandom_range(23)];
         send(op, page);
      end
   endtask

   initial begin
      page_pool[0] = '0;
      page_pool[1] = '1;
      for (int i = 2; i < 24; i++) page_pool[i] = PAGE_W'($urandom);
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send(OP_PUSH, '0);
      send(OP_PUSH, '1);
      send(OP_TOUCH, '0);
      send(OP_TOUCH, 20'h5);
      send(OP_REMOVE, 20'h7);
      send(OP_TICK, '1);
      send(OP_TICK, '0);
      send(OP_PUSH, '0);
      send(OP_REMOVE, '1);
      send(OP_REMOVE, '0);
      send(OP_TICK, 20'h3);
      send(OP_TOUCH, '0);
      for (int i = 0; i < 17; i++) begin
         send(OP_PUSH, PAGE_W'(i + 100));
         if (i < 15) send(OP_TOUCH, PAGE_W'(i + 100));
      end
      send(OP_PUSH, PAGE_W'(200));

      random_phase(0);
      random_phase(20);
      set_policy(MODE_LIFO);
      random_phase(0);
      set_policy(MODE_LEAST);
      random_phase(10);
      set_policy(2'd3);
      random_phase(20);
      set_policy(MODE_SECOND);
      random_phase(0);
      req_ch.valid <= 0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("Covered %0d requests over all policy settings: %0d evictions, %0d hits.",
               sent, evict_count, hit_count);
      if (fail_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule
